>>> hw/rtl/indexed_min_heap_decrease_key_unit_assert.svh
// assertion macros used by the rtl datapath
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH

// same-cycle implication
`define IMH_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imh assertion failed");

// next-cycle implication
`define IMH_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imh assertion failed");

`endif

>>> hw/rtl/imh_pkg.sv
`default_nettype none
package imh_pkg;
  localparam int CAPACITY   = 1024;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int NODE_W     = 10;
  localparam int NODE_SPACE = 1024;
  localparam int KEY_W      = 32;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int ENTRY_W    = 11;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 24;
  localparam int OP_W       = 5;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXT   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [OP_W-1:0] S_CLR    = 5'd0;
  localparam logic [OP_W-1:0] S_IDLE   = 5'd1;
  localparam logic [OP_W-1:0] S_DISP   = 5'd2;
  localparam logic [OP_W-1:0] S_SEED   = 5'd3;
  localparam logic [OP_W-1:0] S_POSCHK = 5'd4;
  localparam logic [OP_W-1:0] S_INSKEY = 5'd5;
  localparam logic [OP_W-1:0] S_UPRD   = 5'd6;
  localparam logic [OP_W-1:0] S_UPCMP  = 5'd7;
  localparam logic [OP_W-1:0] S_UPSW   = 5'd8;
  localparam logic [OP_W-1:0] S_EXTOP  = 5'd9;
  localparam logic [OP_W-1:0] S_EXLAST = 5'd10;
  localparam logic [OP_W-1:0] S_DNL    = 5'd11;
  localparam logic [OP_W-1:0] S_DNR    = 5'd12;
  localparam logic [OP_W-1:0] S_DNRC   = 5'd13;
  localparam logic [OP_W-1:0] S_DNDEC  = 5'd14;
  localparam logic [OP_W-1:0] S_DNSW   = 5'd15;
  localparam logic [OP_W-1:0] S_OUT    = 5'd16;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } slot_t;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic present;
    logic full;
    logic empty;
    logic cnt_one;
    logic idx_zero;
    logic up_stop;
    logic l_out;
    logic r_out;
    logic dn_swap;
    logic clr_done;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/imh_ctrl.sv
`default_nettype none
module imh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire imh_pkg::stat_t stat,
  output imh_pkg::cmd_t      cmd
);
  import imh_pkg::*;

  logic [OP_W-1:0] state_r, state_nxt;
  logic            seed_r, seed_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign cmd.load  = in_tready & in_tvalid;
  assign cmd.op    = state_r;

  always_comb begin
    state_nxt = state_r;
    seed_nxt  = seed_r;
    case (state_r)
      S_CLR: begin
        if (stat.clr_done) begin
          state_nxt = seed_r ? S_SEED : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.load) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (stat.req)
          REQ_START: begin
            state_nxt = S_CLR;
            seed_nxt  = 1'b1;
          end
          REQ_DEC: state_nxt = S_POSCHK;
          REQ_EXT: state_nxt = stat.empty ? S_OUT : S_EXTOP;
          default: state_nxt = S_OUT;
        endcase
      end
      S_SEED: begin
        seed_nxt  = 1'b0;
        state_nxt = S_OUT;
      end
      S_POSCHK: begin
        if (stat.present)   state_nxt = S_UPRD;
        else if (stat.full) state_nxt = S_OUT;
        else                state_nxt = S_INSKEY;
      end
      S_INSKEY: state_nxt = S_UPRD;
      S_UPRD:   state_nxt = stat.idx_zero ? S_OUT : S_UPCMP;
      S_UPCMP:  state_nxt = stat.up_stop ? S_OUT : S_UPSW;
      S_UPSW:   state_nxt = S_UPRD;
      S_EXTOP:  state_nxt = stat.cnt_one ? S_OUT : S_EXLAST;
      S_EXLAST: state_nxt = S_DNL;
      S_DNL:    state_nxt = stat.l_out ? S_OUT : S_DNR;
      S_DNR:    state_nxt = stat.r_out ? S_DNDEC : S_DNRC;
      S_DNRC:   state_nxt = S_DNDEC;
      S_DNDEC:  state_nxt = stat.dn_swap ? S_DNSW : S_OUT;
      S_DNSW:   state_nxt = S_DNL;
      S_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      seed_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/imh_dp.sv
`default_nettype none
module imh_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire imh_pkg::cmd_t               cmd,
  output imh_pkg::stat_t                   stat,
  input  wire logic [imh_pkg::REQ_W-1:0]   in_req,
  input  wire logic [imh_pkg::NODE_W-1:0]  in_node,
  input  wire logic [imh_pkg::KEY_W-1:0]   in_key,
  input  wire logic                        cfg_wr_en,
  input  wire logic [imh_pkg::KEY_W-1:0]   cfg_wr_data,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [imh_pkg::OUT_W-1:0]        out_tdata
);
  import imh_pkg::*;

  slot_t             slot_mem [CAPACITY];
  logic [SLOT_W:0]   pos_mem  [NODE_SPACE];

  slot_t             slot_rd_r;
  logic [SLOT_W:0]   pos_rd_r;
  logic              slot_we, pos_we;
  logic [SLOT_W-1:0] slot_wa, slot_ra;
  slot_t             slot_wd;
  logic [NODE_W-1:0] pos_wa, pos_ra;
  logic [SLOT_W:0]   pos_wd;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [KEY_W-1:0]  kinf_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [NODE_W-1:0] res_node_r, res_node_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [REQ_W-1:0]  req_r;
  logic [NODE_W-1:0] node_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt, oth_r, oth_nxt;
  logic [KEY_W-1:0]  ikey_r, ikey_nxt, bkey_r, bkey_nxt;
  logic [NODE_W-1:0] inode_r, inode_nxt, bnode_r, bnode_nxt;

  logic [CNT_W:0]    lchild, rchild;
  logic [SLOT_W-1:0] parent;
  logic              out_free;

  assign lchild   = (CNT_W+1)'({idx_r, 1'b1});
  assign rchild   = lchild + 1'b1;
  assign parent   = SLOT_W'((idx_r - 1'b1) >> 1);
  assign out_free = !out_tvalid_r || out_tready;

  assign stat.req      = req_r;
  assign stat.present  = pos_rd_r[SLOT_W];
  assign stat.full     = (cnt_r == CNT_W'(CAPACITY));
  assign stat.empty    = (cnt_r == '0);
  assign stat.cnt_one  = (cnt_r == CNT_W'(1));
  assign stat.idx_zero = (idx_r == '0);
  assign stat.up_stop  = (slot_rd_r.key <= ikey_r);
  assign stat.l_out    = (lchild >= (CNT_W+1)'(cnt_r));
  assign stat.r_out    = (rchild >= (CNT_W+1)'(cnt_r));
  assign stat.dn_swap  = (bkey_r < ikey_r);
  assign stat.clr_done = (clr_r == NODE_W'(NODE_SPACE - 1));
  assign stat.out_free = out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
    pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0; pos_ra  = node_r;
    cnt_nxt = cnt_r; clr_nxt = clr_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    res_valid_nxt = res_valid_r; res_node_nxt = res_node_r; status_nxt = status_r;
    idx_nxt = idx_r; oth_nxt = oth_r;
    ikey_nxt = ikey_r; inode_nxt = inode_r; bkey_nxt = bkey_r; bnode_nxt = bnode_r;
    if (cmd.load) begin
      res_valid_nxt = 1'b0;
      res_node_nxt  = '0;
      status_nxt    = ST_OK;
    end
    case (cmd.op)
      S_CLR: begin
        pos_we  = 1'b1;
        pos_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_DISP: begin
        clr_nxt = '0;
        if (req_r == REQ_EXT && stat.empty) status_nxt = ST_EMPTY;
      end
      S_SEED: begin
        slot_we = 1'b1;
        slot_wd = '{node: node_r, key: key_r};
        pos_we  = 1'b1;
        pos_wa  = node_r;
        pos_wd  = {1'b1, SLOT_W'(0)};
        cnt_nxt = CNT_W'(1);
      end
      S_POSCHK: begin
        ikey_nxt  = key_r;
        inode_nxt = node_r;
        if (stat.present) begin
          idx_nxt = pos_rd_r[SLOT_W-1:0];
          slot_we = 1'b1;
          slot_wa = pos_rd_r[SLOT_W-1:0];
          slot_wd = '{node: node_r, key: key_r};
        end else if (stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          idx_nxt = cnt_r[SLOT_W-1:0];
          slot_we = 1'b1;
          slot_wa = cnt_r[SLOT_W-1:0];
          slot_wd = '{node: node_r, key: kinf_r};
          pos_we  = 1'b1;
          pos_wa  = node_r;
          pos_wd  = {1'b1, cnt_r[SLOT_W-1:0]};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_INSKEY: begin
        slot_we = 1'b1;
        slot_wa = idx_r;
        slot_wd = '{node: inode_r, key: ikey_r};
      end
      S_UPRD: begin
        slot_ra = parent;
        oth_nxt = parent;
      end
      S_UPCMP: begin
        if (!stat.up_stop) begin
          slot_we = 1'b1;
          slot_wa = idx_r;
          slot_wd = slot_rd_r;
          pos_we  = 1'b1;
          pos_wa  = slot_rd_r.node;
          pos_wd  = {1'b1, idx_r};
        end
      end
      S_UPSW, S_DNSW: begin
        slot_we = 1'b1;
        slot_wa = oth_r;
        slot_wd = '{node: inode_r, key: ikey_r};
        pos_we  = 1'b1;
        pos_wa  = inode_r;
        pos_wd  = {1'b1, oth_r};
        idx_nxt = oth_r;
      end
      S_EXTOP: begin
        res_node_nxt  = slot_rd_r.node;
        res_valid_nxt = 1'b1;
        pos_we        = 1'b1;
        pos_wa        = slot_rd_r.node;
        slot_ra       = SLOT_W'(cnt_r - 1'b1);
        if (stat.cnt_one) cnt_nxt = '0;
      end
      S_EXLAST: begin
        ikey_nxt  = slot_rd_r.key;
        inode_nxt = slot_rd_r.node;
        cnt_nxt   = cnt_r - 1'b1;
        slot_we   = 1'b1;
        slot_wd   = slot_rd_r;
        pos_we    = 1'b1;
        pos_wa    = slot_rd_r.node;
        pos_wd    = {1'b1, SLOT_W'(0)};
        idx_nxt   = '0;
      end
      S_DNL: begin
        slot_ra = lchild[SLOT_W-1:0];
        oth_nxt = lchild[SLOT_W-1:0];
      end
      S_DNR: begin
        bkey_nxt  = slot_rd_r.key;
        bnode_nxt = slot_rd_r.node;
        slot_ra   = rchild[SLOT_W-1:0];
      end
      S_DNRC: begin
        if (slot_rd_r.key < bkey_r) begin
          bkey_nxt  = slot_rd_r.key;
          bnode_nxt = slot_rd_r.node;
          oth_nxt   = oth_r + 1'b1;
        end
      end
      S_DNDEC: begin
        if (stat.dn_swap) begin
          slot_we = 1'b1;
          slot_wa = idx_r;
          slot_wd = '{node: bnode_r, key: bkey_r};
          pos_we  = 1'b1;
          pos_wa  = bnode_r;
          pos_wd  = {1'b1, idx_r};
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {ENTRY_W'(cnt_r), status_r, res_valid_r, res_node_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      clr_r        <= '0;
      kinf_r       <= '1;
      out_tvalid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      res_valid_r  <= res_valid_nxt;
      if (cfg_wr_en) kinf_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    res_node_r  <= res_node_nxt;
    status_r    <= status_nxt;
    idx_r       <= idx_nxt;
    oth_r       <= oth_nxt;
    ikey_r      <= ikey_nxt;
    inode_r     <= inode_nxt;
    bkey_r      <= bkey_nxt;
    bnode_r     <= bnode_nxt;
    if (cmd.load) begin
      req_r  <= in_req;
      node_r <= in_node;
      key_r  <= in_key;
    end
  end

  `include "indexed_min_heap_decrease_key_unit_assert.svh"

  `IMH_AST_IMP(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `IMH_AST_NXT(a_ext_dec, cmd.op == S_EXLAST, cnt_r == $past(cnt_r) - 1'b1)
  `IMH_AST_IMP(a_res_ok, res_valid_r, status_r == ST_OK)
endmodule
`default_nettype wire

>>> hw/rtl/indexed_min_heap_decrease_key_unit.sv
// sequence to out_tvalid: start clears the position map and seeds the root; type 3 or extract from
//   empty output at once; decrease-key checks the map (output if full), writes the key (twice on insert)
//   and climbs; extract takes the root, then unless it was last moves the last entry up and sifts down
// throughput: one request at a time, next accept in the cycle out_tvalid rises at the earliest,
//   held in the output state while a result waits; sifts bounded by 10 levels
// reset: position map cleared (all 1024 entries) before in_tready rises, heap empty, key_infinity all ones
`default_nettype none
module indexed_min_heap_decrease_key_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [imh_pkg::IN_W-1:0]    in_tdata,  // node_id, new_key, zero pad
  input  wire logic [imh_pkg::REQ_W-1:0]   in_tuser,  // req_type
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [imh_pkg::OUT_W-1:0]        out_tdata, // result_node, result_valid, status, entry_count
  input  wire logic                        cfg_wr_en,
  input  wire logic [imh_pkg::KEY_W-1:0]   cfg_wr_data
);
  import imh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  imh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_req      (in_tuser),
    .in_node     (in_tdata[NODE_W-1:0]),
    .in_key      (in_tdata[NODE_W+KEY_W-1:NODE_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );
endmodule
`default_nettype wire

>>> test/indexed_min_heap_decrease_key_unit_tb.sv
`default_nettype none
module indexed_min_heap_decrease_key_unit_tb;
  import imh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } heap_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic               valid;
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] count;
  } heap_res_t;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [KEY_W-1:0] cfg_wr_data = '0;

  indexed_min_heap_decrease_key_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [KEY_W-1:0]   inf_key = '1;
  logic [NODE_W-1:0]  h_node [CAPACITY];
  logic [KEY_W-1:0]   h_key [CAPACITY];
  int unsigned        node_slot [NODE_SPACE];
  bit                 node_in [NODE_SPACE];
  int unsigned        h_count = 0;

  heap_req_t pending_reqs [$];
  heap_res_t expected_results [$];
  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [NODE_W-1:0] n;
    logic [KEY_W-1:0] k;
    n = h_node[a]; h_node[a] = h_node[b]; h_node[b] = n;
    k = h_key[a]; h_key[a] = h_key[b]; h_key[b] = k;
    node_slot[h_node[a]] = a;
    node_slot[h_node[b]] = b;
  endfunction

  function automatic void climb(input int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (h_key[p] <= h_key[i]) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void descend(input int unsigned i);
    int unsigned l, best;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < h_count && h_key[l] < h_key[best]) best = l;
      if (l + 1 < h_count && h_key[l + 1] < h_key[best]) best = l + 1;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic heap_res_t heap_apply(input heap_req_t r);
    heap_res_t res;
    logic [NODE_W-1:0] top;
    bit ok;
    res = '0;
    case (r.req)
      REQ_START: begin
        foreach (node_in[i]) node_in[i] = 1'b0;
        h_node[0] = r.node;
        h_key[0] = r.key;
        node_slot[r.node] = 0;
        node_in[r.node] = 1'b1;
        h_count = 1;
      end
      REQ_DEC: begin
        ok = 1'b1;
        if (!node_in[r.node]) begin
          if (h_count >= CAPACITY) begin
            res.status = ST_FULL;
            ok = 1'b0;
          end else begin
            h_node[h_count] = r.node;
            h_key[h_count] = inf_key;
            node_slot[r.node] = h_count;
            node_in[r.node] = 1'b1;
            h_count++;
          end
        end
        if (ok) begin
          h_key[node_slot[r.node]] = r.key;
          climb(node_slot[r.node]);
        end
      end
      REQ_EXT: begin
        if (h_count == 0) res.status = ST_EMPTY;
        else begin
          top = h_node[0];
          if (h_count > 1) begin
            swap_slots(0, h_count - 1);
            h_count--;
            descend(0);
          end else h_count = 0;
          node_in[top] = 1'b0;
          res.node = top;
          res.valid = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = h_count[ENTRY_W-1:0];
    return res;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(heap_apply(heap_req_t'({in_tuser, in_tdata[9:0],
                                                           in_tdata[41:10]})));
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else if (!in_tvalid && in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (!in_tvalid && pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_reqs[0].req;
        in_tdata <= {6'd0, pending_reqs[0].key, pending_reqs[0].node};
        void'(pending_reqs.pop_front());
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    heap_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = heap_res_t'({out_tdata[9:0], out_tdata[10], out_tdata[12:11], out_tdata[23:13]});
        if (expected_results.size() == 0) report("result transaction with none expected");
        else begin
          want = expected_results.pop_front();
          if (got.node !== want.node)
            report($sformatf("result_node %0d exp %0d", got.node, want.node));
          if (got.valid !== want.valid)
            report($sformatf("result_valid %0b exp %0b", got.valid, want.valid));
          if (got.status !== want.status)
            report($sformatf("status %0d exp %0d", got.status, want.status));
          if (got.count !== want.count)
            report($sformatf("entry_count %0d exp %0d", got.count, want.count));
        end
        out_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
        out_tready <= (out_gap == 0);
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= (out_gap == 0);
      end else out_tready <= 1'b1;
    end
  end

  function automatic heap_req_t mk(input logic [REQ_W-1:0] q, input int unsigned n,
                                   input logic [KEY_W-1:0] k);
    heap_req_t r;
    r.req = q; r.node = n[NODE_W-1:0]; r.key = k;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_inf(input logic [KEY_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    inf_key = v;
  endtask

  initial begin
    int unsigned sz, pool;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    pending_reqs.push_back(mk(REQ_NONE, 1023, '1));
    pending_reqs.push_back(mk(REQ_DEC, 1023, '1));
    pending_reqs.push_back(mk(REQ_DEC, 0, 0));
    pending_reqs.push_back(mk(REQ_DEC, 5, 32'h0001_0000));
    pending_reqs.push_back(mk(REQ_DEC, 5, 32'h0000_8000));
    pending_reqs.push_back(mk(REQ_DEC, 0, 32'h0002_0000));
    pending_reqs.push_back(mk(REQ_DEC, 682, 32'hAAAA_AAAA));
    pending_reqs.push_back(mk(REQ_DEC, 341, 32'h5555_5555));
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    pending_reqs.push_back(mk(REQ_START, 7, 100));
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    pending_reqs.push_back(mk(REQ_START, 1023, 0));
    drain();
    write_inf(32'd0);
    pending_reqs.push_back(mk(REQ_DEC, 9, 50));
    pending_reqs.push_back(mk(REQ_DEC, 10, 1));
    pending_reqs.push_back(mk(REQ_EXT, 0, 0));
    drain();
    write_inf(32'h0008_0000);
    // fill to capacity, then update a node that is present while full
    for (int i = 0; i < 1024; i++) pending_reqs.push_back(mk(REQ_DEC, i, $urandom));
    pending_reqs.push_back(mk(REQ_DEC, 3, 1));
    drain();
    write_inf(32'hFFFF_FFFF);
    pending_reqs.push_back(mk(REQ_START, 1, 0));
    pending_reqs.push_back(mk(REQ_DEC, 0, 0));
    for (int i = 0; i < 1024; i++) node_in[i] = node_in[i];
    drain();
    // random phases: node pools of 32 or all 1024 nodes, shortest-path style mixes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) write_inf(32'h0000_0000);
      else if (ph == 5) write_inf($urandom);
      else if (ph == 7) write_inf(32'hFFFF_FFFF);
      pending_reqs.push_back(mk(REQ_START, $urandom_range(0, 1023), rand_key()));
      pool = ($urandom_range(0, 1)) ? 32 : 1024;
      sz = 37;
      for (int i = 0; i < sz; i++) begin
        case ($urandom_range(0, 19))
          0: pending_reqs.push_back(mk(REQ_NONE, $urandom_range(0, 1023), $urandom));
          1, 2, 3, 4, 5, 6, 7:
            pending_reqs.push_back(mk(REQ_EXT, $urandom_range(0, 1023), $urandom));
          default: pending_reqs.push_back(mk(REQ_DEC, $urandom_range(0, pool - 1) |
                                              ($urandom_range(0, 1) << 9) % pool,
                                              rand_key()));
        endcase
      end
      drain();
    end
    if (errors == 0) $display("** indexed_min_heap_decrease_key_unit: PASSED **");
    else $display("** indexed_min_heap_decrease_key_unit: FAILED **");
    $finish;
  end

  initial begin
    #(4ns * 2000000);
    $display("** indexed_min_heap_decrease_key_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
